// ----- rtl/core/rwa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_pkg: shared constants of the running window average unit
// Field widths and register reset value, used by the core and its checker.
// ----------------------------------------------------------------------------
package rwa_pkg;

  // sample and average width
  localparam int SAMPLE_W = 16;

  // window length register width and reset value
  localparam int LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  // largest window the register can express
  localparam int LEN_MAX = (1 << LEN_W) - 1;

endpackage

// ----- rtl/core/running_window_average_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_window_average_unit: simple moving average of 16-bit samples
// Flow: a taken request passes S_READ, the bit-serial divider in S_DIV and S_OUT
//   before its result is registered; a new request is taken only once the
//   previous result has been loaded into the output register.
// Reset: synchronous, active low; a clearing pass then zeroes the sample
//   memory one entry a cycle, with in_tready low.
// ----------------------------------------------------------------------------
module running_window_average_unit
  import rwa_pkg::*;
#(
  parameter int MAX_WINDOW = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration: window length
  input  logic                cfg_wr_en,
  input  logic [LEN_W-1:0]    cfg_wr_data,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [15:0] sample
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata   // [15:0] average
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int SW = SAMPLE_W + AW;
  localparam int CW = $clog2(SW);
  localparam int NMAX = (MAX_WINDOW < LEN_MAX) ? MAX_WINDOW : LEN_MAX;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [LEN_W-1:0]    len_r;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [LEN_W-1:0]    div_n_r, div_n_nxt;
  logic [SW-1:0]       quo_r, quo_nxt;
  logic [LEN_W-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]       div_cnt_r, div_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  logic [LEN_W-1:0]    eff_len;
  logic [LEN_W-1:0]    pos_wrap;
  logic [LEN_W:0]      trial;
  logic                in_req;

  assign in_tready  = (state_r == S_IDLE);
  assign in_req     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // effective window: zero counts as one, saturate at the buffer depth or LEN_MAX, whichever is smaller
  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_r) > NMAX) begin
      eff_len = LEN_W'(NMAX);
    end else begin
      eff_len = len_r;
    end
  end

  // write position wraps once it reaches the window
  assign pos_wrap = (pos_r >= eff_len) ? '0 : pos_r;

  // divider trial subtract on the shifted remainder
  assign trial = {rem_r, quo_r[SW-1]} - {1'b0, div_n_r};

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    clr_cnt_nxt   = clr_cnt_r;
    idx_nxt       = idx_r;
    sample_nxt    = sample_r;
    div_n_nxt     = div_n_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = sample_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MAX_WINDOW - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_req) begin
          idx_nxt    = AW'(pos_wrap);
          pos_nxt    = pos_wrap + LEN_W'(1);
          sample_nxt = in_tdata;
          div_n_nxt  = eff_len;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        // old entry is out of memory now: update sum, store new sample
        mem_we      = 1'b1;
        sum_nxt     = sum_r - SW'(rd_data_r) + SW'(sample_r);
        quo_nxt     = sum_r - SW'(rd_data_r) + SW'(sample_r);
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (!trial[LEN_W]) begin
          rem_nxt = trial[LEN_W-1:0];
          quo_nxt = {quo_r[SW-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[LEN_W-2:0], quo_r[SW-1]};
          quo_nxt = {quo_r[SW-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + CW'(1);
        if (div_cnt_r == CW'(SW - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // load the result once the output slot is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (|quo_r[SW-1:SAMPLE_W]) begin
            out_data_nxt = '1;
          end else begin
            out_data_nxt = quo_r[SAMPLE_W-1:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    sample_r   <= sample_nxt;
    div_n_r    <= div_n_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // sample memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[AW'(pos_wrap)];
  end

endmodule

// ----- rtl/core/rwa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwa_checker: port-level checks of the running window average unit
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module rwa_checker
  import rwa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [SAMPLE_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // the unit is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one in progress");

  // reset empties the output and holds in_tready low
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output or input active after reset");

endmodule

bind running_window_average_unit rwa_checker u_rwa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
